### rtl/core/bti_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bti_pkg
// shared types and constants of the breakpoint table interpolator
// ----------------------------------------------------------------------------
package bti_pkg;

	localparam int TABLE_DEPTH_DEF = 64;
	localparam int DATA_W          = 32;
	localparam int INDEX_W         = 6;
	localparam int COUNT_W         = 7;
	localparam int PROD_W          = 2 * DATA_W;

	localparam logic [COUNT_W-1:0] ENTRY_COUNT_RST = 7'd2;

	// operation codes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// status codes
	localparam logic ST_OK    = 1'b0;
	localparam logic ST_RANGE = 1'b1;

	typedef struct packed {
		logic                      operation;
		logic [INDEX_W-1:0]        entry_index;
		logic [DATA_W-1:0]         entry_time;
		logic signed [DATA_W-1:0]  entry_load;
		logic [DATA_W-1:0]         query_time;
	} cmd_t;

	typedef struct packed {
		logic signed [DATA_W-1:0]  result_value;
		logic                      status;
	} result_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_MUL,
		S_LAUNCH,
		S_DIV
	} bti_state_t;

	typedef struct packed {
		logic               start;
		logic [PROD_W-1:0]  dividend;
		logic [DATA_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [DATA_W-1:0]  quotient;
		logic [DATA_W-1:0]  remainder;
	} div_rsp_t;

endpackage

### rtl/core/breakpoint_table_interpolator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// breakpoint_table_interpolator
// piecewise linear lookup over a table of (time, load) breakpoints
// ----------------------------------------------------------------------------
// usage
//   command channel: an item is taken on a clock edge with start high and
//   busy low. operation OP_WRITE stores entry_time/entry_load at entry_index
//   (indexes beyond the table are dropped); OP_QUERY looks up query_time.
//   result channel: every item gives one result, shown on result for exactly
//   one cycle with done high. the receiver cannot stall, so it must take it.
//   config channel: cfg_data (entry count) is written when cfg_valid and
//   cfg_ready are high; cfg_ready is always high. write only while idle.
// write and query flow
//   a write is stored at the accepting edge, its result follows on the next
//   cycle and busy never rises, so writes can go back to back.
//   a query walks the table in one ram, one entry per cycle, over the
//   clamped entry count, stopping early on an exact time match. an
//   interpolation then passes the multiply and launch states and the
//   bit-serial divider; the scan is bound by the single ram read port, and
//   busy stays high until the result, so one query runs at a time.
// reset
//   arst_n clears control and sets the entry count to two. table contents
//   are not cleared and must be written before they are queried.
// ----------------------------------------------------------------------------
module breakpoint_table_interpolator
	import bti_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// command channel
	input  logic               start,
	output logic               busy,
	input  cmd_t               cmd,
	// result channel
	output logic               done,
	output result_t            result,
	// config channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [COUNT_W-1:0] cfg_data
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int RW = 2 * DATA_W;

	// state and registers
	bti_state_t                state_q, state_d;
	logic [COUNT_W-1:0]        count_q;
	logic [AW-1:0]             idx_q;
	logic                      issue_q;
	logic                      rvalid_s1;
	logic [AW-1:0]             ridx_s1;
	logic [DATA_W-1:0]         query_q;
	logic                      pair_q;
	logic [DATA_W-1:0]         prev_time_q;
	logic signed [DATA_W-1:0]  prev_load_q;
	logic [DATA_W-1:0]         t0_q, t1_q;
	logic signed [DATA_W-1:0]  l0_q, l1_q;
	logic [PROD_W-1:0]         prod_q;
	logic [DATA_W-1:0]         span_q;
	logic                      neg_q;
	logic                      done_q;
	result_t                   result_q;

	// combinational
	logic [CW-1:0]             eff_count;
	logic [AW-1:0]             last_idx;
	logic                      accept;
	logic                      wr_en;
	logic [RW-1:0]             rdata;
	logic [DATA_W-1:0]         rd_time;
	logic signed [DATA_W-1:0]  rd_load;
	logic                      hit;
	logic                      pair_hit;
	logic                      scan_last;
	logic                      neg_d;
	logic [DATA_W-1:0]         mag_d;
	logic [DATA_W-1:0]         ofs_d;
	logic                      round_up;
	logic [DATA_W:0]           quo_r;
	logic signed [DATA_W+1:0]  blend;
	div_req_t                  div_req;
	div_rsp_t                  div_rsp;

	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	// entry count clamped to [2, TABLE_DEPTH]
	always_comb begin
		if (32'(count_q) > 32'(TABLE_DEPTH)) begin
			eff_count = CW'(TABLE_DEPTH);
		end else if (count_q < 7'd2) begin
			eff_count = CW'(2);
		end else begin
			eff_count = CW'(count_q);
		end
	end
	assign last_idx = AW'(eff_count - CW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= ENTRY_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			count_q <= cfg_data;
		end
	end

	// breakpoint table: time in the upper half, load in the lower half
	assign wr_en = accept && (cmd.operation == OP_WRITE)
		&& (32'(cmd.entry_index) < 32'(TABLE_DEPTH));

	bti_ram #(
		.WIDTH (RW),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (wr_en),
		.waddr (AW'(cmd.entry_index)),
		.wdata ({cmd.entry_time, cmd.entry_load}),
		.raddr (idx_q),
		.rdata (rdata)
	);

	assign rd_time = rdata[RW-1:DATA_W];
	assign rd_load = rdata[DATA_W-1:0];

	// scan decisions on the entry that just came out of the ram
	assign hit       = rvalid_s1 && (rd_time == query_q);
	assign pair_hit  = rvalid_s1 && (ridx_s1 != '0) && !pair_q
		&& (prev_time_q < query_q) && (query_q < rd_time);
	assign scan_last = rvalid_s1 && (ridx_s1 == last_idx);

	// next state and outputs
	always_comb begin
		state_d          = state_q;
		busy             = (state_q != S_IDLE);
		div_req.start    = 1'b0;
		div_req.dividend = prod_q;
		div_req.divisor  = span_q;
		case (state_q)
			S_IDLE: begin
				if (accept && cmd.operation == OP_QUERY) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (hit) begin
					state_d = S_IDLE;
				end else if (scan_last) begin
					state_d = (pair_q || pair_hit) ? S_MUL : S_IDLE;
				end
			end
			S_MUL: begin
				state_d = S_LAUNCH;
			end
			S_LAUNCH: begin
				div_req.start = 1'b1;
				state_d       = S_DIV;
			end
			S_DIV: begin
				if (div_rsp.done) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// scan control: issue one read per cycle, the data returns in the next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			issue_q   <= 1'b0;
			rvalid_s1 <= 1'b0;
			pair_q    <= 1'b0;
		end else begin
			if (state_q == S_IDLE) begin
				idx_q     <= '0;
				issue_q   <= accept && (cmd.operation == OP_QUERY);
				rvalid_s1 <= 1'b0;
				pair_q    <= 1'b0;
			end else if (state_q == S_SCAN) begin
				rvalid_s1 <= issue_q && (state_d == S_SCAN);
				if (issue_q) begin
					if (idx_q == last_idx) begin
						issue_q <= 1'b0;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				if (pair_hit) begin
					pair_q <= 1'b1;
				end
			end else begin
				rvalid_s1 <= 1'b0;
			end
		end
	end

	// scan payload
	always_ff @(posedge clk) begin
		if (accept) begin
			query_q <= cmd.query_time;
		end
		ridx_s1 <= idx_q;
		if (rvalid_s1) begin
			prev_time_q <= rd_time;
			prev_load_q <= rd_load;
		end
		if (pair_hit) begin
			t0_q <= prev_time_q;
			l0_q <= prev_load_q;
			t1_q <= rd_time;
			l1_q <= rd_load;
		end
	end

	// slope term: |l1 - l0| * (q - t0), divided by t1 - t0
	assign neg_d = l1_q < l0_q;
	assign mag_d = neg_d ? DATA_W'({l0_q[DATA_W-1], l0_q} - {l1_q[DATA_W-1], l1_q})
	                     : DATA_W'({l1_q[DATA_W-1], l1_q} - {l0_q[DATA_W-1], l0_q});
	assign ofs_d = query_q - t0_q;

	always_ff @(posedge clk) begin
		if (state_q == S_MUL) begin
			prod_q <= PROD_W'(mag_d) * PROD_W'(ofs_d);
			span_q <= t1_q - t0_q;
			neg_q  <= neg_d;
		end
	end

	bti_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// round to nearest, ties away from zero, then apply the sign
	assign round_up = {div_rsp.remainder, 1'b0} >= {1'b0, span_q};
	assign quo_r    = {1'b0, div_rsp.quotient} + (DATA_W + 1)'(round_up);
	assign blend    = neg_q
		? ({{2{l0_q[DATA_W-1]}}, l0_q} - $signed({1'b0, quo_r}))
		: ({{2{l0_q[DATA_W-1]}}, l0_q} + $signed({1'b0, quo_r}));

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (accept && cmd.operation == OP_WRITE)
				|| (state_q == S_SCAN && state_d == S_IDLE)
				|| (state_q == S_DIV && div_rsp.done);
		end
	end

	always_ff @(posedge clk) begin
		if (accept && cmd.operation == OP_WRITE) begin
			result_q.result_value <= '0;
			result_q.status       <= ST_OK;
		end else if (state_q == S_SCAN && hit) begin
			result_q.result_value <= rd_load;
			result_q.status       <= ST_OK;
		end else if (state_q == S_SCAN && state_d == S_IDLE) begin
			// walked the whole table without a match or an enclosing pair
			result_q.result_value <= '0;
			result_q.status       <= ST_RANGE;
		end else if (state_q == S_DIV && div_rsp.done) begin
			result_q.result_value <= blend[DATA_W-1:0];
			result_q.status       <= ST_OK;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// checks
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while still busy");

	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_RANGE) |-> (result.result_value == '0))
		else $error("out of range result is not zero");

	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rvalid_s1 |-> (state_q == S_SCAN))
		else $error("table read data pending outside the scan");

	a_div_after_launch: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && $past(state_q) != S_DIV) |-> $past(state_q == S_LAUNCH))
		else $error("divide entered without a launch");

endmodule

### rtl/core/bti_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bti_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
module bti_ram #(
	parameter  int WIDTH = 64,
	parameter  int DEPTH = 64,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/core/bti_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bti_div
// restoring divider, one quotient bit per cycle; needs dividend < divisor<<32
// ----------------------------------------------------------------------------
module bti_div
	import bti_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(DATA_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] low_q;
	logic [DATA_W-1:0] div_q;
	logic [DATA_W:0]   trial;
	logic              take;

	assign trial = {rem_q, low_q[DATA_W-1]};
	assign take  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DATA_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: quotient bits shift into the low word
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.dividend[PROD_W-1:DATA_W];
			low_q <= req.dividend[DATA_W-1:0];
			div_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= take ? DATA_W'(trial - {1'b0, div_q}) : trial[DATA_W-1:0];
			low_q <= {low_q[DATA_W-2:0], take};
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = low_q;
	assign rsp.remainder = rem_q;

endmodule
